### sv/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the front, queue, back and top-level files; depends on nothing.
`default_nettype none
package u16u8_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [0:0] REG_COUNT_ONLY = 1'b0;
	localparam logic [0:0] REG_CAPACITY   = 1'b1;

	localparam logic [15:0] CAPACITY_RST = 16'd768;

	localparam logic [5:0]  HIGH_TAG   = 6'b110110;
	localparam logic [5:0]  LOW_TAG    = 6'b110111;
	localparam logic [15:0] MAX_ONE    = 16'h007f;
	localparam logic [15:0] MAX_TWO    = 16'h07ff;
	localparam logic [10:0] PLANE_ADD  = 11'h040;
	localparam logic [7:0]  LEAD_TWO   = 8'hc0;
	localparam logic [7:0]  LEAD_THREE = 8'he0;
	localparam logic [7:0]  LEAD_FOUR  = 8'hf0;
	localparam logic [7:0]  CONT       = 8'h80;
	localparam logic [3:0]  SURR_HI    = 4'hd;

	typedef struct packed {
		logic [31:0] bytes;
		logic [1:0]  last_idx;
		logic        end_mark;
		logic [15:0] total;
		logic        truncated;
	} entry_t;

endpackage
`default_nettype wire

### sv/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, checks capacity and
// keeps the byte count. Emits a queue entry per terminator and per fitting
// character outside count mode. Depends on u16u8_pkg.
`default_nettype none
module u16u8_front #(
	parameter int COUNT_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    count_only,
	input  wire  [15:0]            capacity,
	input  wire                    unit_valid,
	output logic                   unit_ready,
	input  wire  [15:0]            unit,
	input  wire                    q_room,
	output logic                   push,
	output u16u8_pkg::entry_t      entry
);

	localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

	logic [9:0]            held_q, n_held;
	logic                  held_valid_q, n_held_valid;
	logic [COUNT_BITS-1:0] bytes_done_q, n_bytes_done;
	logic                  stopped_q, n_stopped;
	logic                  replay_q;
	logic [15:0]           replay_unit_q;

	logic                  act;
	logic [15:0]           u;
	logic                  ch_valid, term, rep;
	logic [2:0]            ch_k;
	logic [31:0]           ch_bytes;
	logic [10:0]           z;
	logic [COUNT_BITS:0]   sum_k;
	logic [SW-1:0]         sum_fit;
	logic                  fits;
	logic [SW-1:0]         done_ext;

	assign unit_ready = q_room && !replay_q;
	assign act        = replay_q ? q_room : (unit_valid && q_room);
	assign u          = replay_q ? replay_unit_q : unit;
	assign z          = {1'b0, held_q} + u16u8_pkg::PLANE_ADD;
	assign sum_k      = {1'b0, bytes_done_q} + (COUNT_BITS+1)'(ch_k);
	assign sum_fit    = SW'(bytes_done_q) + SW'(ch_k) + SW'(1);
	assign fits       = sum_fit <= SW'(capacity);
	assign done_ext   = SW'(bytes_done_q);

	always_comb begin
		n_held       = held_q;
		n_held_valid = held_valid_q;
		n_bytes_done = bytes_done_q;
		n_stopped    = stopped_q;
		push         = 1'b0;
		entry        = '0;
		ch_valid     = 1'b0;
		ch_k         = 3'd0;
		ch_bytes     = '0;
		term         = 1'b0;
		rep          = 1'b0;
		if (act) begin
			if (held_valid_q) begin
				n_held_valid = 1'b0;
				ch_valid     = 1'b1;
				if (u[15:10] == u16u8_pkg::LOW_TAG) begin
					ch_k     = 3'd4;
					ch_bytes = {u16u8_pkg::CONT | {2'b00, u[5:0]},
						u16u8_pkg::CONT | {2'b00, z[1:0], u[9:6]},
						u16u8_pkg::CONT | {2'b00, z[7:2]},
						u16u8_pkg::LEAD_FOUR | {5'b00000, z[10:8]}};
				end else begin
					ch_k     = 3'd3;
					ch_bytes = {8'h00,
						u16u8_pkg::CONT | {2'b00, held_q[5:0]},
						u16u8_pkg::CONT | {2'b00, 2'b10, held_q[9:6]},
						u16u8_pkg::LEAD_THREE | {4'h0, u16u8_pkg::SURR_HI}};
					rep      = 1'b1;
				end
			end else if (u == 16'h0000) begin
				term = 1'b1;
			end else if (!stopped_q) begin
				if (u <= u16u8_pkg::MAX_ONE) begin
					ch_valid = 1'b1;
					ch_k     = 3'd1;
					ch_bytes = {24'h000000, u[7:0]};
				end else if (u <= u16u8_pkg::MAX_TWO) begin
					ch_valid = 1'b1;
					ch_k     = 3'd2;
					ch_bytes = {16'h0000, u16u8_pkg::CONT | {2'b00, u[5:0]},
						u16u8_pkg::LEAD_TWO | {3'b000, u[10:6]}};
				end else if (u[15:10] == u16u8_pkg::HIGH_TAG) begin
					n_held       = u[9:0];
					n_held_valid = 1'b1;
				end else begin
					ch_valid = 1'b1;
					ch_k     = 3'd3;
					ch_bytes = {8'h00, u16u8_pkg::CONT | {2'b00, u[5:0]},
						u16u8_pkg::CONT | {2'b00, u[11:6]},
						u16u8_pkg::LEAD_THREE | {4'h0, u[15:12]}};
				end
			end
		end

		if (ch_valid && !stopped_q) begin
			if (count_only || fits) begin
				n_bytes_done = sum_k[COUNT_BITS] ? '1 : sum_k[COUNT_BITS-1:0];
				if (!count_only) begin
					push           = 1'b1;
					entry.bytes    = ch_bytes;
					entry.last_idx = 2'(ch_k - 3'd1);
				end
			end else begin
				n_stopped = 1'b1;
			end
		end

		if (term) begin
			push            = 1'b1;
			entry.bytes     = '0;
			entry.last_idx  = 2'd0;
			entry.end_mark  = 1'b1;
			entry.total     = done_ext[15:0];
			entry.truncated = stopped_q;
			n_held          = '0;
			n_held_valid    = 1'b0;
			n_bytes_done    = '0;
			n_stopped       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			bytes_done_q <= '0;
			stopped_q    <= 1'b0;
			replay_q     <= 1'b0;
		end else begin
			held_q       <= n_held;
			held_valid_q <= n_held_valid;
			bytes_done_q <= n_bytes_done;
			stopped_q    <= n_stopped;
			if (act) begin
				replay_q <= rep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && rep) begin
			replay_unit_q <= u;
		end
	end

endmodule
`default_nettype wire

### sv/u16u8_queue.sv
// Short register queue of character entries between front and back.
// Depends on u16u8_pkg for the entry type and depth.
`default_nettype none
module u16u8_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  u16u8_pkg::entry_t      push_entry,
	input  wire                    pop,
	output u16u8_pkg::entry_t      head,
	output logic                   not_empty,
	output logic                   room
);

	u16u8_pkg::entry_t              mem_q [u16u8_pkg::QDEPTH];
	logic [u16u8_pkg::QAW-1:0]      wptr_q, rptr_q;
	logic [u16u8_pkg::QAW:0]        count_q;
	logic                           do_pop;

	assign not_empty = count_q != '0;
	assign room      = count_q != (u16u8_pkg::QAW+1)'(u16u8_pkg::QDEPTH);
	assign head      = mem_q[rptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/u16u8_back.sv
// Back end: walks the bytes of the head entry and drives the output register.
// Depends on u16u8_pkg.
`default_nettype none
module u16u8_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  u16u8_pkg::entry_t      head,
	input  wire                    not_empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [23:0]            m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser
);

	logic [1:0] idx_q;
	logic       load;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [15:0] total_q;
	logic       last_q, trunc_q;

	assign load     = not_empty && (!out_valid_q || m_tready);
	assign pop      = load && (idx_q == head.last_idx);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {total_q, byte_q};
	assign m_tlast  = last_q;
	assign m_tuser  = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= pop ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= head.bytes[{idx_q, 3'b000} +: 8];
			total_q <= head.total;
			last_q  <= head.end_mark;
			trunc_q <= head.truncated;
		end
	end

endmodule
`default_nettype wire

### sv/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder top level: configuration registers, front, queue
// and back. Depends on u16u8_pkg and the u16u8 front, queue and back modules.
//
// One UTF-16 code unit is taken per input word and a zero unit ends the
// string; the output gives one UTF-8 byte per word, one word per cycle
// while m_tready is high, so a character yields one to four output words
// by its encoded length, the terminator one and a character in count mode
// none (a lone high surrogate makes the front replay the next unit). The
// front classifies code units while the queue has room, and a four-entry
// queue lets it run ahead of the byte serializer; sustained rate is set by
// the output byte rate. The last word of a string carries byte zero, tlast,
// the byte count and, in tuser, the truncation flag. Configuration must be
// written only while the block is idle; the block does not enforce this.
`default_nettype none
module utf16_to_utf8_encoder #(
	parameter int COUNT_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_idx,
	input  wire  [15:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // code_unit[15:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // out_byte[7:0], byte_total[23:8]
	output logic        m_tlast,   // end_mark
	output logic        m_tuser    // truncated
);

	logic              count_only_q;
	logic [15:0]       capacity_q;
	logic              q_room, q_not_empty, f_push, b_pop;
	u16u8_pkg::entry_t f_entry, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			capacity_q   <= u16u8_pkg::CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				u16u8_pkg::REG_COUNT_ONLY: count_only_q <= cfg_data[0];
				u16u8_pkg::REG_CAPACITY:   capacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	u16u8_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_only (count_only_q),
		.capacity   (capacity_q),
		.unit_valid (s_tvalid),
		.unit_ready (s_tready),
		.unit       (s_tdata),
		.q_room     (q_room),
		.push       (f_push),
		.entry      (f_entry)
	);

	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_push),
		.push_entry (f_entry),
		.pop        (b_pop),
		.head       (q_head),
		.not_empty  (q_not_empty),
		.room       (q_room)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.not_empty (q_not_empty),
		.pop       (b_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

### sv/u16u8_checker.sv
// Port-level checks for the UTF-16 to UTF-8 encoder, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module u16u8_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tlast,
	input wire        m_tuser
);

	a_term_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
		else $error("terminator word carries a nonzero byte");

	a_plain_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'h0000 && !m_tuser)
		else $error("data word carries a count or truncation flag");

	a_trunc_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("truncation flag outside the final word");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
